/* hw/rtl/ufgr_pkg.sv */
// ----------------------------------------------------------------------------
// ufgr_pkg: shared definitions for the UART frame gap receiver
// Request codes, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package ufgr_pkg;

    // Parameter defaults
    localparam int DEPTH_DEF     = 256;
    localparam int MAX_BURST_DEF = 64;

    // Fixed field widths
    localparam int REQ_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int GAP_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_RX_BYTE    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TICK       = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READ       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ERASE      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CHK_FRAME  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_CHK_SEEN   = 3'd6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STATION_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_ADDR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS    = 2'd2;

    // Register reset values
    localparam logic [GAP_W-1:0] GAP_TICKS_RST = 16'd5;

endpackage

/* hw/rtl/uart_frame_gap_receiver_unit.sv */
// ----------------------------------------------------------------------------
// uart_frame_gap_receiver_unit: UART receive store with idle-gap framing
// Stores good bytes in a ring, ends frames after a tick-counted silence,
// filters frames by address, and serves host reads, erases and flag checks.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                  | payload
//  request   | in        | i_in_valid / o_in_ready    | req_type rx_data rx_error amount remove
//  result    | out       | o_out_valid / i_out_ready  | data_byte data_valid last byte_count
//            |           |                            | frame_event byte_seen
//  config    | in        | i_cfg_we (no wait)         | i_cfg_idx i_cfg_data
//
// Non-read request: accept, an execute state (S_EXEC), then the result register
// is loaded (S_DONE); the next request is accepted only once the result is taken.
// Read of n bytes: the store has a registered read port, so each byte walks an
// address state and a data state (S_RD_ADDR, S_RD_DATA) before it is loaded.
// A new request is taken only when the sequencer is idle and the result
// register is empty. A stalled result holds the sequencer in place.
// Reset (synchronous, active low) clears pointers, timer, flags, registers.
// ----------------------------------------------------------------------------
module uart_frame_gap_receiver_unit #(
    parameter int DEPTH     = ufgr_pkg::DEPTH_DEF,
    parameter int MAX_BURST = ufgr_pkg::MAX_BURST_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ufgr_pkg::REQ_W-1:0]        i_req_type,
    input  logic [ufgr_pkg::BYTE_W-1:0]       i_rx_data,
    input  logic                              i_rx_error,
    input  logic [ufgr_pkg::BYTE_W-1:0]       i_amount,
    input  logic                              i_remove,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ufgr_pkg::BYTE_W-1:0]       o_data_byte,
    output logic                              o_data_valid,
    output logic                              o_last,
    output logic [ufgr_pkg::BYTE_W-1:0]       o_byte_count,
    output logic                              o_frame_event,
    output logic                              o_byte_seen,
    // configuration port
    input  logic                              i_cfg_we,
    input  logic [ufgr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ufgr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CW    = (PTR_W > ufgr_pkg::BYTE_W) ? PTR_W : ufgr_pkg::BYTE_W;
    localparam int BW    = $clog2(MAX_BURST + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(DEPTH);
    localparam logic [CW-1:0]    BURST_CW  = CW'(MAX_BURST);
    localparam logic [CW-1:0]    SAT_CW    = CW'(255);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_ADDR,
        S_RD_DATA,
        S_DONE
    } t_state;

    // Sequencer and state registers
    t_state                         r_state;
    logic [PTR_W-1:0]               r_head;
    logic [PTR_W-1:0]               r_tail;
    logic [ufgr_pkg::GAP_W-1:0]     r_gap_timer;
    logic                           r_frame_ready;
    logic                           r_address_ok;
    logic                           r_byte_flag;

    // Configuration registers
    logic [ufgr_pkg::BYTE_W-1:0]    r_station_addr;
    logic                           r_check_addr;
    logic [ufgr_pkg::GAP_W-1:0]     r_gap_ticks;

    // Latched request
    logic [ufgr_pkg::REQ_W-1:0]     r_req;
    logic [ufgr_pkg::BYTE_W-1:0]    r_rx_data;
    logic                           r_rx_error;
    logic [ufgr_pkg::BYTE_W-1:0]    r_amount;
    logic                           r_remove;

    // Pending single result
    logic [ufgr_pkg::BYTE_W-1:0]    r_res_count;
    logic                           r_res_use_sat;
    logic                           r_res_fev;
    logic                           r_res_seen;

    // Read burst walker
    logic [PTR_W-1:0]               r_rd_ptr;
    logic [BW-1:0]                  r_idx;
    logic [BW-1:0]                  r_burst_len;

    // Result register
    logic                           r_out_valid;
    logic [ufgr_pkg::BYTE_W-1:0]    r_out_data;
    logic                           r_out_dvalid;
    logic                           r_out_last;
    logic [ufgr_pkg::BYTE_W-1:0]    r_out_count;
    logic                           r_out_fev;
    logic                           r_out_seen;

    // Store
    logic [ufgr_pkg::BYTE_W-1:0]    r_store [DEPTH];
    logic [ufgr_pkg::BYTE_W-1:0]    r_mem_q;

    // Combinational helpers
    logic [PTR_W-1:0]               n_count;
    logic [ufgr_pkg::BYTE_W-1:0]    n_sat_count;
    logic [CW-1:0]                  n_min_amt;
    logic [PTR_W-1:0]               n_take;
    logic [BW-1:0]                  n_burst;
    logic                           n_has_room;
    logic                           n_store_wr;
    logic                           n_out_free;
    logic                           n_out_load;
    logic                           n_exec_fev;
    logic                           n_in_acc;
    logic                           n_burst_end;
    logic [PTR_W-1:0]               u_a;
    logic [PTR_W-1:0]               u_b;
    logic [PTR_W:0]                 u_sum;
    logic [PTR_W-1:0]               u_res;

    assign n_in_acc   = i_in_valid && o_in_ready;
    assign n_out_free = !r_out_valid || i_out_ready;

    // Result register takes a new item
    assign n_out_load = ((r_state == S_RD_DATA) || (r_state == S_DONE)) && n_out_free;

    // Stored count, ring distance from head to tail
    always_comb begin
        if (r_tail >= r_head) begin
            n_count = r_tail - r_head;
        end else begin
            n_count = PTR_W'((PTR_W + 1)'(r_tail) + DEPTH_EXT - (PTR_W + 1)'(r_head));
        end
    end

    assign n_sat_count = (CW'(n_count) > SAT_CW) ? ufgr_pkg::BYTE_W'(SAT_CW)
                                                 : ufgr_pkg::BYTE_W'(CW'(n_count));
    assign n_has_room  = (n_count < PTR_LAST);

    // Bytes to read or erase: min of amount and count (fits the pointer)
    assign n_min_amt = (CW'(n_count) < CW'(r_amount)) ? CW'(n_count) : CW'(r_amount);
    assign n_take    = PTR_W'(n_min_amt);
    assign n_burst   = (n_min_amt > BURST_CW) ? BW'(MAX_BURST) : BW'(n_min_amt);

    assign n_burst_end = ((r_idx + BW'(1)) == r_burst_len);

    // Frame event: tick ending an accepted frame, or frame check hit
    assign n_exec_fev = ((r_req == ufgr_pkg::REQ_TICK)
                         && (r_gap_timer == ufgr_pkg::GAP_W'(1))
                         && ((r_station_addr == '0) || r_address_ok))
                        || ((r_req == ufgr_pkg::REQ_CHK_FRAME) && r_frame_ready);

    // Shared ring-pointer adder: a + b modulo DEPTH
    always_comb begin
        priority if (r_state == S_RD_DATA) begin
            u_a = r_rd_ptr;
            u_b = PTR_W'(1);
        end else if (r_req == ufgr_pkg::REQ_RX_BYTE) begin
            u_a = r_tail;
            u_b = PTR_W'(1);
        end else begin
            u_a = r_head;
            u_b = n_take;
        end
    end

    assign u_sum = (PTR_W + 1)'(u_a) + (PTR_W + 1)'(u_b);
    assign u_res = (u_sum >= DEPTH_EXT) ? PTR_W'(u_sum - DEPTH_EXT) : PTR_W'(u_sum);

    assign n_store_wr = (r_state == S_EXEC) && (r_req == ufgr_pkg::REQ_RX_BYTE)
                        && !r_rx_error && n_has_room;

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (n_store_wr) begin
            r_store[r_tail] <= r_rx_data;
        end
        r_mem_q <= r_store[r_rd_ptr];
    end

    // Request latch
    always_ff @(posedge i_clk) begin
        if (n_in_acc) begin
            r_req      <= i_req_type;
            r_rx_data  <= i_rx_data;
            r_rx_error <= i_rx_error;
            r_amount   <= i_amount;
            r_remove   <= i_remove;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_addr <= '0;
            r_check_addr   <= 1'b0;
            r_gap_ticks    <= ufgr_pkg::GAP_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ufgr_pkg::REG_STATION_ADDR: begin
                    r_station_addr <= i_cfg_data[ufgr_pkg::BYTE_W-1:0];
                end
                ufgr_pkg::REG_CHECK_ADDR: begin
                    r_check_addr <= i_cfg_data[0];
                end
                ufgr_pkg::REG_GAP_TICKS: begin
                    r_gap_ticks <= i_cfg_data[ufgr_pkg::GAP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer, receive state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_head        <= '0;
            r_tail        <= '0;
            r_gap_timer   <= '0;
            r_frame_ready <= 1'b0;
            r_address_ok  <= 1'b0;
            r_byte_flag   <= 1'b0;
            r_out_valid   <= 1'b0;
            r_res_use_sat <= 1'b0;
            r_res_count   <= '0;
            r_res_fev     <= 1'b0;
            r_res_seen    <= 1'b0;
            r_rd_ptr      <= '0;
            r_idx         <= '0;
            r_burst_len   <= '0;
        end else begin
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_in_acc) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res_use_sat <= (r_req != ufgr_pkg::REQ_READ)
                                     && (r_req != ufgr_pkg::REQ_ERASE)
                                     && (r_req != ufgr_pkg::REQ_CLEAR);
                    r_res_count   <= (r_req == ufgr_pkg::REQ_ERASE)
                                     ? ufgr_pkg::BYTE_W'(n_min_amt) : '0;
                    r_res_fev     <= n_exec_fev;
                    r_res_seen    <= (r_req == ufgr_pkg::REQ_CHK_SEEN) && r_byte_flag;
                    r_state       <= ((r_req == ufgr_pkg::REQ_READ) && (n_burst != '0))
                                     ? S_RD_ADDR : S_DONE;
                    unique case (r_req)
                        ufgr_pkg::REQ_RX_BYTE: begin
                            r_byte_flag <= 1'b1;
                            if (!r_rx_error) begin
                                if (n_has_room) begin
                                    r_tail <= u_res;
                                    if (r_check_addr && (n_count == '0) &&
                                        ((r_rx_data == r_station_addr) ||
                                         (r_rx_data == '0))) begin
                                        r_address_ok <= 1'b1;
                                    end
                                end
                                r_gap_timer <= r_gap_ticks;
                            end
                        end
                        ufgr_pkg::REQ_TICK: begin
                            if (r_gap_timer != '0) begin
                                r_gap_timer <= r_gap_timer - ufgr_pkg::GAP_W'(1);
                                if (r_gap_timer == ufgr_pkg::GAP_W'(1)) begin
                                    if ((r_station_addr == '0) || r_address_ok) begin
                                        r_frame_ready <= 1'b1;
                                    end else begin
                                        r_head <= '0;
                                        r_tail <= '0;
                                    end
                                    r_address_ok <= 1'b0;
                                end
                            end
                        end
                        ufgr_pkg::REQ_READ: begin
                            if (n_burst != '0) begin
                                r_rd_ptr    <= r_head;
                                r_idx       <= '0;
                                r_burst_len <= n_burst;
                            end
                        end
                        ufgr_pkg::REQ_ERASE: begin
                            r_head <= u_res;
                        end
                        ufgr_pkg::REQ_CLEAR: begin
                            r_head        <= '0;
                            r_tail        <= '0;
                            r_frame_ready <= 1'b0;
                        end
                        ufgr_pkg::REQ_CHK_FRAME: begin
                            if (r_frame_ready) begin
                                r_frame_ready <= 1'b0;
                                r_byte_flag   <= 1'b0;
                            end
                        end
                        ufgr_pkg::REQ_CHK_SEEN: begin
                            r_byte_flag <= 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
                S_RD_ADDR: begin
                    // store read issued at r_rd_ptr this cycle
                    r_state <= S_RD_DATA;
                end
                S_RD_DATA: begin
                    if (n_out_free) begin
                        r_out_data   <= r_mem_q;
                        r_out_dvalid <= 1'b1;
                        r_out_last   <= n_burst_end;
                        r_out_count  <= ufgr_pkg::BYTE_W'(r_burst_len);
                        r_out_fev    <= 1'b0;
                        r_out_seen   <= 1'b0;
                        r_rd_ptr     <= u_res;
                        r_idx        <= r_idx + BW'(1);
                        if (n_burst_end) begin
                            if (r_remove) begin
                                r_head <= u_res;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_RD_ADDR;
                        end
                    end
                end
                S_DONE: begin
                    if (n_out_free) begin
                        r_out_data   <= '0;
                        r_out_dvalid <= 1'b0;
                        r_out_last   <= 1'b1;
                        r_out_count  <= r_res_use_sat ? n_sat_count : r_res_count;
                        r_out_fev    <= r_res_fev;
                        r_out_seen   <= r_res_seen;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid   = r_out_valid;
    assign o_data_byte   = r_out_data;
    assign o_data_valid  = r_out_dvalid;
    assign o_last        = r_out_last;
    assign o_byte_count  = r_out_count;
    assign o_frame_event = r_out_fev;
    assign o_byte_seen   = r_out_seen;

    // Pointers stay inside the ring, also for depths that are not powers of two
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= PTR_LAST) && (r_tail <= PTR_LAST))
        else $error("ring pointer out of range");

    // A byte carrying result reports a burst length between one and the cap
    a_burst_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_dvalid) |->
        ((r_out_count != '0) && (CW'(r_out_count) <= BURST_CW)))
        else $error("burst length out of range");

    // A result without a byte always closes its request
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_dvalid) |-> r_out_last)
        else $error("non-data result not marked last");

    // A full store takes no more bytes
    a_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_count == PTR_LAST) |-> !n_store_wr)
        else $error("byte written into a full store");

    // Burst index stays below the burst length while walking
    a_walk_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD_ADDR) || (r_state == S_RD_DATA)) |-> (r_idx < r_burst_len))
        else $error("burst walker overran");

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: request-level testbench for uart_frame_gap_receiver_unit
// Sends requests and takes results over valid/ready, with random idle cycles
// on both sides. Each accepted request is run through a local copy of the
// ring store, gap timer and flags, and every result is compared field by
// field, in order. A short directed table opens the run. Random frame traffic
// under several register settings follows, with one store-filling phase.
// ----------------------------------------------------------------------------
module tb;

    localparam int REQ_W       = ufgr_pkg::REQ_W;
    localparam int BYTE_W      = ufgr_pkg::BYTE_W;
    localparam int GAP_W       = ufgr_pkg::GAP_W;
    localparam int CFG_IDX_W   = ufgr_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = ufgr_pkg::CFG_DATA_W;

    localparam int ST_DEPTH    = ufgr_pkg::DEPTH_DEF;
    localparam int BURST       = ufgr_pkg::MAX_BURST_DEF;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_LIMIT = 50000;
    localparam int MAX_PRINTS  = 50;

    // selector with no function
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    // directed rows: typed result or predicted result
    localparam bit TYPED = 1'b1;
    localparam bit PRED  = 1'b0;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [BYTE_W-1:0] data;
        logic              err;
        logic [BYTE_W-1:0] amount;
        logic              remove;
    } t_rx_req;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              dvalid;
        logic              last;
        logic [BYTE_W-1:0] count;
        logic              fev;
        logic              seen;
    } t_rx_res;

    typedef struct {
        t_rx_req req;
        bit      typed;
        t_rx_res want;
    } t_plan_row;

    // DUT ports
    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_ready;
    logic [REQ_W-1:0]      i_req_type   = '0;
    logic [BYTE_W-1:0]     i_rx_data    = '0;
    logic                  i_rx_error   = 1'b0;
    logic [BYTE_W-1:0]     i_amount     = '0;
    logic                  i_remove     = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready  = 1'b0;
    logic [BYTE_W-1:0]     o_data_byte;
    logic                  o_data_valid;
    logic                  o_last;
    logic [BYTE_W-1:0]     o_byte_count;
    logic                  o_frame_event;
    logic                  o_byte_seen;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;

    // typed expectation riding along with the offered request
    logic    cur_typed = 1'b0;
    t_rx_res cur_want  = '0;

    // local copy of the receiver state and registers
    logic [BYTE_W-1:0] st_mem [ST_DEPTH];
    int                st_head    = 0;
    int                st_tail    = 0;
    logic [GAP_W-1:0]  st_timer   = '0;
    logic              st_ready   = 1'b0;
    logic              st_addr_ok = 1'b0;
    logic              st_seen    = 1'b0;
    logic [BYTE_W-1:0] cfg_station = '0;
    logic              cfg_check   = 1'b0;
    logic [GAP_W-1:0]  cfg_gap     = ufgr_pkg::GAP_TICKS_RST;

    t_rx_res   step_out[$];
    t_rx_res   due_replies[$];
    t_plan_row plan[$];

    int   mismatch_cnt = 0;
    int   n_items      = 0;
    bit   steady_tx    = 1'b0;
    logic steady_rx    = 1'b0;
    logic hold_req     = 1'b0;

    // settings as last programmed, used to shape frames
    logic [BYTE_W-1:0] cur_station = '0;
    logic [GAP_W-1:0]  cur_gap     = ufgr_pkg::GAP_TICKS_RST;

    uart_frame_gap_receiver_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_rx_data     (i_rx_data),
        .i_rx_error    (i_rx_error),
        .i_amount      (i_amount),
        .i_remove      (i_remove),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_data_byte   (o_data_byte),
        .o_data_valid  (o_data_valid),
        .o_last        (o_last),
        .o_byte_count  (o_byte_count),
        .o_frame_event (o_frame_event),
        .o_byte_seen   (o_byte_seen),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic int stored_bytes();
        return (st_tail + ST_DEPTH - st_head) % ST_DEPTH;
    endfunction

    function automatic logic [BYTE_W-1:0] sat_count();
        int n;
        n = stored_bytes();
        return (n > 255) ? 8'd255 : 8'(n);
    endfunction

    function automatic t_rx_res reply(logic [BYTE_W-1:0] data, logic dvalid, logic last,
                                      logic [BYTE_W-1:0] count, logic fev, logic seen);
        t_rx_res r;
        r.data   = data;
        r.dvalid = dvalid;
        r.last   = last;
        r.count  = count;
        r.fev    = fev;
        r.seen   = seen;
        return r;
    endfunction

    // Apply one request to the local state; results go to step_out
    task automatic step_frame_store(t_rx_req r);
        int   n;
        int   i;
        logic fev;
        logic seen;
        step_out.delete();
        n   = stored_bytes();
        fev = 1'b0;
        case (r.kind)
            ufgr_pkg::REQ_RX_BYTE: begin
                st_seen = 1'b1;
                // errored byte only marks arrival
                if (!r.err) begin
                    if (n + 1 < ST_DEPTH) begin
                        st_mem[st_tail] = r.data;
                        if (cfg_check && n == 0 &&
                            (r.data == cfg_station || r.data == 8'h00))
                            st_addr_ok = 1'b1;
                        st_tail = (st_tail + 1) % ST_DEPTH;
                    end
                    st_timer = cfg_gap;
                end
                step_out.push_back(reply('0, 1'b0, 1'b1, sat_count(), 1'b0, 1'b0));
            end
            ufgr_pkg::REQ_TICK: begin
                if (st_timer != 0) begin
                    st_timer = st_timer - 1'b1;
                    // frame end: keep or discard
                    if (st_timer == 0) begin
                        if (cfg_station == 0 || st_addr_ok) begin
                            st_ready = 1'b1;
                            fev      = 1'b1;
                        end else begin
                            st_head = 0;
                            st_tail = 0;
                        end
                        st_addr_ok = 1'b0;
                    end
                end
                step_out.push_back(reply('0, 1'b0, 1'b1, sat_count(), fev, 1'b0));
            end
            ufgr_pkg::REQ_READ: begin
                if (n > r.amount) n = r.amount;
                if (n > BURST) n = BURST;
                if (n == 0) begin
                    step_out.push_back(reply('0, 1'b0, 1'b1, '0, 1'b0, 1'b0));
                end else begin
                    for (i = 0; i < n; i++)
                        step_out.push_back(reply(st_mem[(st_head + i) % ST_DEPTH], 1'b1,
                                                 (i + 1 == n), 8'(n), 1'b0, 1'b0));
                    if (r.remove) st_head = (st_head + n) % ST_DEPTH;
                end
            end
            ufgr_pkg::REQ_ERASE: begin
                if (n > r.amount) n = r.amount;
                st_head = (st_head + n) % ST_DEPTH;
                step_out.push_back(reply('0, 1'b0, 1'b1, 8'(n), 1'b0, 1'b0));
            end
            ufgr_pkg::REQ_CLEAR: begin
                st_head  = 0;
                st_tail  = 0;
                st_ready = 1'b0;
                step_out.push_back(reply('0, 1'b0, 1'b1, '0, 1'b0, 1'b0));
            end
            ufgr_pkg::REQ_CHK_FRAME: begin
                if (st_ready) begin
                    st_ready = 1'b0;
                    st_seen  = 1'b0;
                    fev      = 1'b1;
                end
                step_out.push_back(reply('0, 1'b0, 1'b1, sat_count(), fev, 1'b0));
            end
            ufgr_pkg::REQ_CHK_SEEN: begin
                seen    = st_seen;
                st_seen = 1'b0;
                step_out.push_back(reply('0, 1'b0, 1'b1, sat_count(), 1'b0, seen));
            end
            default: begin
                step_out.push_back(reply('0, 1'b0, 1'b1, sat_count(), 1'b0, 1'b0));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(string what, int got, int want);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTS)
            $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic check_reply(t_rx_res got);
        t_rx_res want;
        if (due_replies.size() == 0) begin
            flag_mismatch("result with nothing expected, byte_count", got.count, 0);
        end else begin
            want = due_replies.pop_front();
            if (got.data !== want.data)     flag_mismatch("data_byte", got.data, want.data);
            if (got.dvalid !== want.dvalid) flag_mismatch("data_valid", got.dvalid, want.dvalid);
            if (got.last !== want.last)     flag_mismatch("last", got.last, want.last);
            if (got.count !== want.count)   flag_mismatch("byte_count", got.count, want.count);
            if (got.fev !== want.fev)       flag_mismatch("frame_event", got.fev, want.fev);
            if (got.seen !== want.seen)     flag_mismatch("byte_seen", got.seen, want.seen);
        end
    endtask

    // Register writes, accepted requests and delivered results, all at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ufgr_pkg::REG_STATION_ADDR: cfg_station = i_cfg_data[BYTE_W-1:0];
                    ufgr_pkg::REG_CHECK_ADDR:   cfg_check   = i_cfg_data[0];
                    ufgr_pkg::REG_GAP_TICKS:    cfg_gap     = i_cfg_data[GAP_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                step_frame_store({i_req_type, i_rx_data, i_rx_error, i_amount, i_remove});
                if (cur_typed) due_replies.push_back(cur_want);
                else foreach (step_out[k]) due_replies.push_back(step_out[k]);
            end
            if (o_out_valid && i_out_ready)
                check_reply({o_data_byte, o_data_valid, o_last, o_byte_count,
                             o_frame_event, o_byte_seen});
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, steady mode, long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req <= 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (steady_rx) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 30);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    function automatic t_plan_row row(logic [REQ_W-1:0] kind, logic [7:0] data, logic err,
                                      logic [7:0] amount, logic remove, bit typed,
                                      logic [7:0] w_data, logic w_valid, logic [7:0] w_count,
                                      logic w_fev, logic w_seen);
        t_plan_row p;
        p.req   = '{kind: kind, data: data, err: err, amount: amount, remove: remove};
        p.typed = typed;
        p.want  = reply(w_data, w_valid, 1'b1, w_count, w_fev, w_seen);
        return p;
    endfunction

    function automatic t_rx_req any_req(logic [REQ_W-1:0] kind);
        t_rx_req r;
        r.kind   = kind;
        r.data   = 8'($urandom);
        r.err    = 1'($urandom);
        r.amount = 8'($urandom);
        r.remove = 1'($urandom);
        return r;
    endfunction

    // Hold one request until accepted, then maybe idle
    task automatic offer(t_rx_req r, bit typed, t_rx_res want);
        i_in_valid <= 1'b1;
        i_req_type <= r.kind;
        i_rx_data  <= r.data;
        i_rx_error <= r.err;
        i_amount   <= r.amount;
        i_remove   <= r.remove;
        cur_typed  <= typed;
        cur_want   <= want;
        do @(posedge i_clk); while (!o_in_ready);
        n_items++;
        if (!steady_tx && $urandom_range(99) < 30) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send(t_rx_req r);
        offer(r, PRED, '0);
    endtask

    // Stop offering and wait until every expected result has come
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [7:0] station, logic check, logic [15:0] gap);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ufgr_pkg::REG_STATION_ADDR;
        i_cfg_data <= CFG_DATA_W'(station);
        @(posedge i_clk);
        i_cfg_idx  <= ufgr_pkg::REG_CHECK_ADDR;
        i_cfg_data <= CFG_DATA_W'(check);
        @(posedge i_clk);
        i_cfg_idx  <= ufgr_pkg::REG_GAP_TICKS;
        i_cfg_data <= gap;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_station = station;
        cur_gap     = gap;
    endtask

    // Mostly whole frames (bytes, ticks to the gap, host service), some noise
    task automatic frame_traffic(int budget);
        t_rx_req r;
        int      stop_at;
        int      nbytes;
        int      nticks;
        int      i;
        stop_at = n_items + budget;
        while (n_items < stop_at) begin
            if ($urandom_range(99) < 70) begin
                nbytes = $urandom_range(1, 6);
                for (i = 0; i < nbytes; i++) begin
                    r     = any_req(ufgr_pkg::REQ_RX_BYTE);
                    r.err = ($urandom_range(99) < 8);
                    // first byte: own address, broadcast or anything
                    if (i == 0) begin
                        case ($urandom_range(0, 3))
                            0, 1:    r.data = cur_station;
                            2:       r.data = 8'h00;
                            default: ;
                        endcase
                    end
                    send(r);
                end
                nticks = (cur_gap > 6) ? $urandom_range(1, 3)
                                       : int'(cur_gap) + $urandom_range(0, 1);
                for (i = 0; i < nticks; i++) send(any_req(ufgr_pkg::REQ_TICK));
                if ($urandom_range(99) < 80) send(any_req(ufgr_pkg::REQ_CHK_FRAME));
                if ($urandom_range(99) < 70) begin
                    r        = any_req(ufgr_pkg::REQ_READ);
                    r.amount = 8'($urandom_range(0, 12));
                    send(r);
                end
                if ($urandom_range(99) < 40) begin
                    r        = any_req(ufgr_pkg::REQ_ERASE);
                    r.amount = 8'($urandom_range(0, 8));
                    send(r);
                end
                if ($urandom_range(99) < 30) send(any_req(ufgr_pkg::REQ_CHK_SEEN));
            end else begin
                send(any_req(REQ_W'($urandom_range(0, 7))));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        t_rx_req r;
        int      waited;
        int      i;

        foreach (st_mem[k]) st_mem[k] = '0;

        // Directed table, reset settings: no filtering, gap of 5 ticks
        // kind, data, err, amt, rm, check, data, vld, cnt, fev, seen
        plan.push_back(row(ufgr_pkg::REQ_CHK_SEEN, 'h00, 0, 'h00, 0, TYPED, 'h00, 0, 0, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_READ, 'h00, 0, 'hFF, 1, TYPED, 'h00, 0, 0, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_TICK, 'h00, 0, 'h00, 0, TYPED, 'h00, 0, 0, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_RX_BYTE, 'h00, 0, 'h00, 0, TYPED, 'h00, 0, 1, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_RX_BYTE, 'hFF, 0, 'hFF, 1, TYPED, 'h00, 0, 2, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_RX_BYTE, 'hA5, 1, 'h00, 0, TYPED, 'h00, 0, 2, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_CHK_SEEN, 'h00, 0, 'h00, 0, TYPED, 'h00, 0, 2, 0, 1));
        plan.push_back(row(ufgr_pkg::REQ_READ, 'h00, 0, 'h01, 0, TYPED, 'h00, 1, 1, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_READ, 'h00, 0, 'hFF, 1, PRED, 'h00, 0, 0, 0, 0));
        plan.push_back(row(REQ_UNUSED, 'hFF, 1, 'hFF, 1, TYPED, 'h00, 0, 0, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_RX_BYTE, 'h5A, 0, 'h00, 0, TYPED, 'h00, 0, 1, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_TICK, 'h00, 0, 'h00, 0, PRED, 'h00, 0, 0, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_TICK, 'hFF, 1, 'hFF, 1, PRED, 'h00, 0, 0, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_TICK, 'h00, 0, 'h00, 0, PRED, 'h00, 0, 0, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_TICK, 'h00, 0, 'h00, 0, PRED, 'h00, 0, 0, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_TICK, 'h00, 0, 'h00, 0, TYPED, 'h00, 0, 1, 1, 0));
        plan.push_back(row(ufgr_pkg::REQ_TICK, 'h00, 0, 'h00, 0, PRED, 'h00, 0, 0, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_CHK_FRAME, 'h00, 0, 'h00, 0, TYPED, 'h00, 0, 1, 1, 0));
        plan.push_back(row(ufgr_pkg::REQ_CHK_SEEN, 'h00, 0, 'h00, 0, TYPED, 'h00, 0, 1, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_CHK_FRAME, 'h00, 0, 'h00, 0, PRED, 'h00, 0, 0, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_ERASE, 'h00, 0, 'h00, 0, TYPED, 'h00, 0, 0, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_ERASE, 'h00, 0, 'hFF, 1, TYPED, 'h00, 0, 1, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_RX_BYTE, 'h11, 0, 'h80, 1, PRED, 'h00, 0, 0, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_RX_BYTE, 'h22, 0, 'h7F, 0, PRED, 'h00, 0, 0, 0, 0));
        plan.push_back(row(ufgr_pkg::REQ_CLEAR, 'h00, 0, 'h00, 0, TYPED, 'h00, 0, 0, 0, 0));

        // Synchronous reset, once
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) offer(plan[k].req, plan[k].typed, plan[k].want);
        settle();

        // Check on with own address zero, one-tick gap; no idling either side
        set_regs(8'h00, 1'b1, 16'd1);
        steady_tx = 1'b1;
        steady_rx <= 1'b1;
        frame_traffic(30);
        settle();
        steady_tx = 1'b0;
        steady_rx <= 1'b0;

        // Address filtering; result side holds off while requests keep coming
        set_regs(8'h3C, 1'b1, 16'd3);
        hold_req <= 1'b1;
        steady_tx = 1'b1;
        repeat (20) send(any_req(REQ_W'($urandom_range(0, 7))));
        steady_tx = 1'b0;
        frame_traffic(30);
        settle();

        // Top address; request side pauses midway until all results are in
        set_regs(8'hFF, 1'b1, 16'd2);
        frame_traffic(15);
        settle();
        frame_traffic(15);
        settle();

        // Own address set but check off: frames are discarded
        set_regs(8'h81, 1'b0, 16'd4);
        frame_traffic(25);
        settle();

        // Longest gap: fill the store past full, then long reads and erases
        set_regs(8'h00, 1'b0, 16'hFFFF);
        send(any_req(ufgr_pkg::REQ_CLEAR));
        for (i = 0; i < 275; i++) begin
            r     = any_req(ufgr_pkg::REQ_RX_BYTE);
            r.err = ($urandom_range(99) < 3);
            send(r);
        end
        r        = any_req(ufgr_pkg::REQ_READ);
        r.amount = 8'hFF;
        r.remove = 1'b0;
        send(r);
        r.remove = 1'b1;
        send(r);
        r        = any_req(ufgr_pkg::REQ_ERASE);
        r.amount = 8'($urandom_range(0, 150));
        send(r);
        frame_traffic(10);

        // Drain with a limit, then let the pipeline go quiet
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (due_replies.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (16) @(posedge i_clk);
        if (due_replies.size() != 0)
            flag_mismatch("results never delivered, count", due_replies.size(), 0);

        if (mismatch_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hang guard
    initial begin : hang_guard
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
